// File: rtl/dq_pkg.sv
package dq_pkg;

    localparam int unsigned DefaultDepth = 128;
    localparam int unsigned WordWidth    = 32;
    localparam int unsigned OccWidth     = 8;

    typedef enum logic [2:0] {
        REQ_PUSH_BACK  = 3'd0,
        REQ_PUSH_FRONT = 3'd1,
        REQ_POP_FRONT  = 3'd2,
        REQ_POP_BACK   = 3'd3,
        REQ_PEEK_FRONT = 3'd4,
        REQ_PEEK_BACK  = 3'd5
    } req_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // the operation that every cell of the row applies
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_SHIFT_UP,    // take left neighbor (push front)
        CELL_SHIFT_DOWN,  // take right neighbor (pop front)
        CELL_FILL_BACK,   // first empty cell loads the word
        CELL_DROP_BACK    // last occupied cell goes empty
    } cell_op_t;

    typedef struct packed {
        cell_op_t               op;
        logic [WordWidth-1:0]   word;
    } cell_ctrl_t;

endpackage

// File: rtl/double_ended_queue.sv
// Bounded deque of signed 32-bit words built as a row of DEPTH cells. The front
// word always sits in cell 0; push front and pop front shift the whole row by one
// cell, push back fills the first empty cell and pop back empties the last
// occupied one. Every request produces one result beat (data, status,
// occupancy), so the block sustains one request per cycle while the result
// side keeps up; the single result register sets that figure. A push onto a
// full queue or a pop/peek on an empty one only reports status.
module double_ended_queue #(
    parameter int unsigned DEPTH = dq_pkg::DefaultDepth
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [31:0] value, rest zero
    input  logic [2:0]  s_tuser,   // [2:0] req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] data, [39:32] occupancy
    output logic [1:0]  m_tuser    // [1:0] status
);
    import dq_pkg::*;

    localparam int unsigned CntWidth = $clog2(DEPTH + 1);

    logic [WordWidth-1:0] cell_word [DEPTH];
    logic [WordWidth-1:0] cell_back [DEPTH];
    logic [DEPTH-1:0]     cell_occ;
    logic [DEPTH-1:0]     back_col [WordWidth];
    logic [WordWidth-1:0] back_data;

    cell_ctrl_t           ctrl;
    cell_op_t             op;
    logic                 accept;
    logic                 full, empty;
    logic [WordWidth-1:0] value;
    req_t                 req;

    logic [CntWidth-1:0]  count_reg, count_next;
    logic [CntWidth+OccWidth-1:0] count_wide;

    logic                 m_valid_reg;
    logic [WordWidth-1:0] data_reg, data_next;
    status_t              status_reg, status_next;
    logic [OccWidth-1:0]  occ_reg;

    assign value  = s_tdata[WordWidth-1:0];
    assign req    = req_t'(s_tuser);
    assign full   = cell_occ[DEPTH-1];
    assign empty  = !cell_occ[0];

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    genvar i, b;
    generate
        for (i = 0; i < DEPTH; i++) begin : g_cell
            logic [WordWidth-1:0] lw, rw;
            logic                 lo, ro;
            if (i == 0) begin : g_first
                assign lw = value;
                assign lo = 1'b1;
            end else begin : g_mid_l
                assign lw = cell_word[i-1];
                assign lo = cell_occ[i-1];
            end
            if (i == DEPTH - 1) begin : g_last
                assign rw = '0;
                assign ro = 1'b0;
            end else begin : g_mid_r
                assign rw = cell_word[i+1];
                assign ro = cell_occ[i+1];
            end
            dq_cell u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .ctrl       (ctrl),
                .left_word  (lw),
                .left_occ   (lo),
                .right_word (rw),
                .right_occ  (ro),
                .word       (cell_word[i]),
                .occ        (cell_occ[i]),
                .back_word  (cell_back[i])
            );
            for (b = 0; b < WordWidth; b++) begin : g_col
                assign back_col[b][i] = cell_back[i][b];
            end
        end
        // at most one cell drives its word as back word, the rest drive zero, so OR selects it
        for (b = 0; b < WordWidth; b++) begin : g_back
            assign back_data[b] = |back_col[b];
        end
    endgenerate

    always_comb begin
        op          = CELL_HOLD;
        data_next   = '0;
        status_next = ST_OK;
        count_next  = count_reg;
        case (req)
            REQ_PUSH_BACK, REQ_PUSH_FRONT: begin
                if (full) begin
                    status_next = ST_FULL;
                end else begin
                    op         = (req == REQ_PUSH_BACK) ? CELL_FILL_BACK : CELL_SHIFT_UP;
                    count_next = count_reg + CntWidth'(1);
                end
            end
            REQ_POP_FRONT: begin
                if (empty) begin
                    status_next = ST_EMPTY;
                end else begin
                    op         = CELL_SHIFT_DOWN;
                    data_next  = cell_word[0];
                    count_next = count_reg - CntWidth'(1);
                end
            end
            REQ_POP_BACK: begin
                if (empty) begin
                    status_next = ST_EMPTY;
                end else begin
                    op         = CELL_DROP_BACK;
                    data_next  = back_data;
                    count_next = count_reg - CntWidth'(1);
                end
            end
            REQ_PEEK_FRONT: begin
                if (empty) status_next = ST_EMPTY;
                else data_next = cell_word[0];
            end
            REQ_PEEK_BACK: begin
                if (empty) status_next = ST_EMPTY;
                else data_next = back_data;
            end
            default: begin
                op = CELL_HOLD;
            end
        endcase
        ctrl.op   = accept ? op : CELL_HOLD;
        ctrl.word = value;
    end

    assign count_wide = {{OccWidth{1'b0}}, count_next};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                count_reg   <= count_next;
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            data_reg   <= data_next;
            status_reg <= status_next;
            occ_reg    <= count_wide[OccWidth-1:0];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {occ_reg, data_reg};
    assign m_tuser  = status_reg;

endmodule

// File: rtl/dq_cell.sv
module dq_cell (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  dq_pkg::cell_ctrl_t              ctrl,
    input  logic [dq_pkg::WordWidth-1:0]    left_word,
    input  logic                            left_occ,
    input  logic [dq_pkg::WordWidth-1:0]    right_word,
    input  logic                            right_occ,
    output logic [dq_pkg::WordWidth-1:0]    word,
    output logic                            occ,
    output logic [dq_pkg::WordWidth-1:0]    back_word
);
    import dq_pkg::*;

    logic [WordWidth-1:0] word_reg, word_next;
    logic                 occ_reg, occ_next;

    always_comb begin
        word_next = word_reg;
        occ_next  = occ_reg;
        case (ctrl.op)
            CELL_SHIFT_UP: begin
                word_next = left_word;
                occ_next  = left_occ;
            end
            CELL_SHIFT_DOWN: begin
                word_next = right_word;
                occ_next  = right_occ;
            end
            CELL_FILL_BACK: begin
                if (!occ_reg && left_occ) begin
                    word_next = ctrl.word;
                    occ_next  = 1'b1;
                end
            end
            CELL_DROP_BACK: begin
                if (occ_reg && !right_occ) begin
                    occ_next = 1'b0;
                end
            end
            default: begin
                word_next = word_reg;
                occ_next  = occ_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        word_reg <= word_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= 1'b0;
        end else begin
            occ_reg <= occ_next;
        end
    end

    assign word      = word_reg;
    assign occ       = occ_reg;
    assign back_word = (occ_reg && !right_occ) ? word_reg : '0;

endmodule
